[rtl/core/deferred_message_timer_table_assert.svh]
// ---------------------------------------------------------------------------
// Deferred message timer table assertion macros
// Shared concurrent assertion forms used by the timer table RTL.
// ---------------------------------------------------------------------------
`ifndef DEFERRED_MESSAGE_TIMER_TABLE_ASSERT_SVH
`define DEFERRED_MESSAGE_TIMER_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DMTT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define DMTT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define DMTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dmtt_pkg.sv]
// ---------------------------------------------------------------------------
// Deferred message timer table package
// Shared constants, codes and record types of the timer table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmtt_pkg;

   localparam int SLOTS_DEF    = 64;
   localparam int GEN_BITS_DEF = 24;

   localparam int DATA_W      = 32;
   localparam int BLOCK_W     = 48;
   localparam int ORDER_W     = 32;
   localparam int RATE_W      = 19;
   localparam int BSIZE_W     = 13;
   localparam int KIND_W      = 2;
   localparam int ACT_W       = 2;
   localparam int CSR_IDX_W   = 4;
   localparam int PEND_OUT_W  = 7;
   localparam int GEN_SHIFT   = 8;
   localparam int HGEN_W      = DATA_W - GEN_SHIFT;
   localparam int DIVIDEND_W  = 51;
   // The divisor is 1000 times the block size, up to 8191000, which does not fit this width.
   localparam int DIVISOR_W   = 22;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

   localparam logic [RATE_W-1:0]    SAMPLE_RATE_RESET = RATE_W'(44100);
   localparam logic [BSIZE_W-1:0]   BLOCK_SIZE_RESET  = BSIZE_W'(512);
   localparam logic [DIVISOR_W-1:0] MS_PER_S          = DIVISOR_W'(1000);
   localparam logic [DATA_W-1:0]    DROP_MAX          = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = CSR_IDX_W'(1);

   typedef enum logic [ACT_W-1:0] {
      ACT_ARM    = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef struct packed {
      logic [DATA_W-1:0]        target;
      logic signed [DATA_W-1:0] tag;
      logic [KIND_W-1:0]        kind;
      logic [DATA_W-1:0]        value;
   } msg_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] due;
      logic [ORDER_W-1:0] order;
      msg_type            msg;
   } rec_type;

   localparam int REC_W     = $bits(rec_type);
   localparam int MEM_W_DEF = REC_W + GEN_BITS_DEF;

   typedef struct packed {
      logic [DATA_W-1:0]     handle_out;
      logic                  ok;
      logic                  delivered;
      msg_type               msg;
      logic                  last;
      logic [PEND_OUT_W-1:0] pending_count;
      logic [DATA_W-1:0]     dropped_count;
   } result_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/dmtt_if.sv]
// ---------------------------------------------------------------------------
// Deferred message timer table channels
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmtt_req_if;
   import dmtt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic [DATA_W-1:0]        target_id;
   logic signed [DATA_W-1:0] msg_tag;
   logic [KIND_W-1:0]        msg_kind;
   logic [DATA_W-1:0]        msg_value;
   logic signed [DATA_W-1:0] delay_ms;
   logic [DATA_W-1:0]        handle_in;

   modport source (output valid, action, target_id, msg_tag, msg_kind, msg_value,
                   delay_ms, handle_in, input ready);
   modport sink (input valid, action, target_id, msg_tag, msg_kind, msg_value,
                 delay_ms, handle_in, output ready);
endinterface

interface dmtt_rsp_if;
   import dmtt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [DATA_W-1:0]        handle_out;
   logic                     ok;
   logic                     delivered;
   logic [DATA_W-1:0]        out_target;
   logic signed [DATA_W-1:0] out_tag;
   logic [KIND_W-1:0]        out_kind;
   logic [DATA_W-1:0]        out_value;
   logic                     last;
   logic [PEND_OUT_W-1:0]    pending_count;
   logic [DATA_W-1:0]        dropped_count;

   modport source (output valid, handle_out, ok, delivered, out_target, out_tag,
                   out_kind, out_value, last, pending_count, dropped_count,
                   input ready);
   modport sink (input valid, handle_out, ok, delivered, out_target, out_tag,
                 out_kind, out_value, last, pending_count, dropped_count,
                 output ready);
endinterface

interface dmtt_csr_if;
   import dmtt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/dmtt_slot_mem.sv]
// ---------------------------------------------------------------------------
// Slot record memory
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmtt_slot_mem #(
   parameter int DEPTH  = dmtt_pkg::SLOTS_DEF,
   parameter int DATA_W = dmtt_pkg::MEM_W_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/core/dmtt_divider.sv]
// ---------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmtt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dmtt_pkg::div_req_type div_req,
   output dmtt_pkg::div_rsp_type div_rsp
);
   import dmtt_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      logic [DIVISOR_W:0] trial;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits its width.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/deferred_message_timer_table.sv]
// ---------------------------------------------------------------------------
// Deferred message timer table
// Slot table of deferred messages with per-slot generation handles.
// ---------------------------------------------------------------------------
// The block handles one request word at a time and can take the next request
// while a finished response word still waits in the output register. Slot
// records live in one memory with a registered read; the armed,
// generation-written and due flags are flip-flops, so no clearing pass is
// needed after reset. A cancel or query reads its slot at accept, checks it
// in S_CHK and then hands off the response. An arm with a positive delay
// waits for one run of the bit-serial divider: the product of milliseconds
// and sample rate, pre-rounded by 1000 times (block_size - 1), is divided by
// 1000 times block_size, which gives the rounded-up block count of the
// truncated sample count in one pass. A refused arm goes straight to its
// response, and an arm with a delay at or below zero skips the divider. A
// tick first makes one pass over the memory to mark the due slots and then
// one full pass over the memory read port for each message it delivers,
// looking for the oldest arm order among the due slots.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deferred_message_timer_table_assert.svh"

module deferred_message_timer_table #(
   parameter int SLOTS    = dmtt_pkg::SLOTS_DEF,
   parameter int GEN_BITS = dmtt_pkg::GEN_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dmtt_req_if.sink   req_ch,
   dmtt_rsp_if.source rsp_ch,
   dmtt_csr_if.sink   csr_ch
);
   import dmtt_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int MEM_W  = REC_W + GEN_BITS;
   localparam int CMP_W  = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

   // One-hot sequencer states.
   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_MUL   = 10'b00_0000_0010,
      S_RND   = 10'b00_0000_0100,
      S_DIV   = 10'b00_0000_1000,
      S_DWAIT = 10'b00_0001_0000,
      S_ARM   = 10'b00_0010_0000,
      S_CHK   = 10'b00_0100_0000,
      S_SCAN  = 10'b00_1000_0000,
      S_SEL   = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   // Latched request fields.
   action_type               act_ff, act_in;
   msg_type                  msg_ff, msg_in;
   logic signed [DATA_W-1:0] delay_ff, delay_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [HGEN_W-1:0]        hgen_ff, hgen_in;
   logic [GEN_BITS-1:0]      gen_ff, gen_in;
   logic [DIVIDEND_W-1:0]    prod_ff, prod_in;

   // Per-slot flags and global counters.
   logic [SLOTS-1:0]   armed_ff, armed_in;
   logic [SLOTS-1:0]   genv_ff, genv_in;
   logic [SLOTS-1:0]   due_ff, due_in;
   logic [CNT_W-1:0]   pend_ff, pend_in;
   logic [DATA_W-1:0]  drop_ff, drop_in;
   logic [BLOCK_W-1:0] now_ff, now_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [BSIZE_W-1:0] bsz_ff, bsz_in;

   // Memory scan and oldest-entry selection.
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rv_ff, rv_in;
   logic [SLOT_W-1:0]  ridx_ff, ridx_in;
   logic               hb_ff, hb_in;
   logic [SLOT_W-1:0]  best_ff, best_in;
   rec_type            brec_ff, brec_in;

   // Response staging and output register.
   result_type res_ff, res_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Memory and divider connections.
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [MEM_W-1:0]    mem_wdata;
   logic [SLOT_W-1:0]   mem_raddr;
   logic [MEM_W-1:0]    mem_rdata;
   rec_type             rrec;
   logic [GEN_BITS-1:0] rgen;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Lowest free slot.
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;

   logic                   acc;
   logic [GEN_SHIFT-1:0]   hidx;
   logic                   hvalid;
   logic [SLOT_W-1:0]      hslot;
   logic [BSIZE_W-1:0]     bs_eff;
   logic [DIVISOR_W-1:0]   div_dsr;

   assign acc     = req_ch.valid && req_ch.ready;
   assign hidx    = req_ch.handle_in[GEN_SHIFT-1:0];
   assign hvalid  = (hidx != '0) && (int'(hidx) <= SLOTS);
   assign hslot   = SLOT_W'(hidx - 1'b1);
   assign bs_eff  = (bsz_ff == '0) ? BSIZE_W'(1) : bsz_ff;
   // Samples per block scaled by milliseconds per second.
   assign div_dsr = MS_PER_S * DIVISOR_W'(bs_eff);
   assign rrec    = rec_type'(mem_rdata[REC_W-1:0]);
   assign rgen    = mem_rdata[MEM_W-1:REC_W];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!armed_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   dmtt_slot_mem #(
      .DEPTH  (SLOTS),
      .DATA_W (MEM_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   dmtt_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      logic                set_res;
      logic                issue;
      logic                match;
      logic [GEN_BITS-1:0] geff;
      logic [SLOTS-1:0]    rest;
      rec_type             wrec;

      state_in = state_ff;
      ret_in   = ret_ff;
      act_in   = act_ff;
      msg_in   = msg_ff;
      delay_in = delay_ff;
      slot_in  = slot_ff;
      hgen_in  = hgen_ff;
      gen_in   = gen_ff;
      prod_in  = prod_ff;
      armed_in = armed_ff;
      genv_in  = genv_ff;
      due_in   = due_ff;
      pend_in  = pend_ff;
      drop_in  = drop_ff;
      now_in   = now_ff;
      order_in = order_ff;
      rate_in  = rate_ff;
      bsz_in   = bsz_ff;
      scan_in  = scan_ff;
      rv_in    = 1'b0;
      ridx_in  = ridx_ff;
      hb_in    = hb_ff;
      best_in  = best_ff;
      brec_in  = brec_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      set_res  = 1'b0;
      issue    = 1'b0;
      match    = 1'b0;
      geff     = '0;
      rest     = due_ff;
      wrec     = '0;

      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = '0;
      mem_raddr = scan_ff[SLOT_W-1:0];

      div_req          = '0;
      div_req.dividend = prod_ff;
      div_req.divisor  = div_dsr;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_SAMPLE_RATE: rate_in = csr_ch.data[RATE_W-1:0];
            CSR_BLOCK_SIZE:  bsz_in  = csr_ch.data[BSIZE_W-1:0];
            default:         rate_in = rate_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            mem_raddr = (action_type'(req_ch.action) == ACT_ARM) ? free_idx : hslot;
            if (acc) begin
               act_in   = action_type'(req_ch.action);
               msg_in   = '{target: req_ch.target_id, tag: req_ch.msg_tag,
                            kind: req_ch.msg_kind, value: req_ch.msg_value};
               delay_in = req_ch.delay_ms;
               hgen_in  = req_ch.handle_in[DATA_W-1:GEN_SHIFT];
               res_in   = '0;
               res_in.last = 1'b1;
               ret_in   = S_IDLE;
               case (action_type'(req_ch.action))
                  ACT_ARM: begin
                     if (req_ch.target_id == '0) begin
                        set_res  = 1'b1;
                        state_in = S_OUT;
                     end else if (!free_found) begin
                        if (drop_ff != DROP_MAX) begin
                           drop_in = drop_ff + 1'b1;
                        end
                        set_res  = 1'b1;
                        state_in = S_OUT;
                     end else begin
                        slot_in  = free_idx;
                        state_in = S_MUL;
                     end
                  end
                  ACT_CANCEL, ACT_QUERY: begin
                     if (hvalid) begin
                        slot_in  = hslot;
                        state_in = S_CHK;
                     end else begin
                        set_res  = 1'b1;
                        state_in = S_OUT;
                     end
                  end
                  ACT_TICK: begin
                     now_in   = now_ff + 1'b1;
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_MUL: begin
            // The slot's record read issued at accept is visible now.
            geff   = genv_ff[slot_ff] ? rgen : '0;
            gen_in = geff + 1'b1;
            if (delay_ff[DATA_W-1] || (delay_ff == '0)) begin
               prod_in  = DIVIDEND_W'(1);
               state_in = S_ARM;
            end else begin
               prod_in  = DIVIDEND_W'(delay_ff[DATA_W-2:0]) * DIVIDEND_W'(rate_ff);
               state_in = S_RND;
            end
         end

         S_RND: begin
            // Adding 1000 * (block_size - 1) rounds the block count up while
            // the sample count itself stays truncated.
            prod_in  = prod_ff + DIVIDEND_W'(div_dsr - MS_PER_S);
            state_in = S_DIV;
         end

         S_DIV: begin
            div_req.start = 1'b1;
            state_in      = S_DWAIT;
         end

         S_DWAIT: begin
            if (div_rsp.done) begin
               prod_in  = (div_rsp.quotient == '0) ? DIVIDEND_W'(1) : div_rsp.quotient;
               state_in = S_ARM;
            end
         end

         S_ARM: begin
            wrec.due   = now_ff + BLOCK_W'(prod_ff);
            wrec.order = order_ff;
            wrec.msg   = msg_ff;
            mem_we     = 1'b1;
            mem_wdata  = {gen_ff, wrec};
            armed_in[slot_ff] = 1'b1;
            genv_in[slot_ff]  = 1'b1;
            pend_in    = pend_ff + 1'b1;
            order_in   = order_ff + 1'b1;
            res_in.handle_out = DATA_W'({gen_ff, GEN_SHIFT'(slot_ff) + GEN_SHIFT'(1)});
            res_in.ok  = 1'b1;
            set_res    = 1'b1;
            state_in   = S_OUT;
         end

         S_CHK: begin
            geff  = genv_ff[slot_ff] ? rgen : '0;
            match = armed_ff[slot_ff] && (CMP_W'(geff) == CMP_W'(hgen_ff));
            if (match && (act_ff == ACT_CANCEL)) begin
               armed_in[slot_ff] = 1'b0;
               pend_in = pend_ff - 1'b1;
            end
            res_in.ok = match;
            set_res   = 1'b1;
            state_in  = S_OUT;
         end

         S_SCAN: begin
            issue   = (scan_ff < CNT_W'(SLOTS));
            rv_in   = issue;
            ridx_in = scan_ff[SLOT_W-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rv_ff && armed_ff[ridx_ff] && (rrec.due <= now_ff)) begin
               due_in[ridx_ff] = 1'b1;
            end
            if (!issue && !rv_ff) begin
               scan_in = '0;
               hb_in   = 1'b0;
               if (due_ff == '0) begin
                  set_res  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SEL;
               end
            end
         end

         S_SEL: begin
            issue   = (scan_ff < CNT_W'(SLOTS));
            rv_in   = issue;
            ridx_in = scan_ff[SLOT_W-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            // Strict compare keeps the lower slot on equal arm order.
            if (rv_ff && due_ff[ridx_ff] && (!hb_ff || (rrec.order < brec_ff.order))) begin
               hb_in   = 1'b1;
               best_in = ridx_ff;
               brec_in = rrec;
            end
            if (!issue && !rv_ff) begin
               rest[best_ff]     = 1'b0;
               due_in[best_ff]   = 1'b0;
               armed_in[best_ff] = 1'b0;
               pend_in           = pend_ff - 1'b1;
               res_in.delivered  = 1'b1;
               res_in.msg        = brec_ff.msg;
               res_in.last       = (rest == '0);
               set_res           = 1'b1;
               scan_in           = '0;
               hb_in             = 1'b0;
               ret_in            = (rest == '0) ? S_IDLE : S_SEL;
               state_in          = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ret_ff;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Counts in a response reflect the state after this word's effect.
      if (set_res) begin
         res_in.pending_count = PEND_OUT_W'(pend_in);
         res_in.dropped_count = drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         armed_ff     <= '0;
         genv_ff      <= '0;
         due_ff       <= '0;
         pend_ff      <= '0;
         drop_ff      <= '0;
         now_ff       <= '0;
         order_ff     <= '0;
         rate_ff      <= SAMPLE_RATE_RESET;
         bsz_ff       <= BLOCK_SIZE_RESET;
         scan_ff      <= '0;
         rv_ff        <= 1'b0;
         hb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         armed_ff     <= armed_in;
         genv_ff      <= genv_in;
         due_ff       <= due_in;
         pend_ff      <= pend_in;
         drop_ff      <= drop_in;
         now_ff       <= now_in;
         order_ff     <= order_in;
         rate_ff      <= rate_in;
         bsz_ff       <= bsz_in;
         scan_ff      <= scan_in;
         rv_ff        <= rv_in;
         hb_ff        <= hb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff   <= act_in;
      msg_ff   <= msg_in;
      delay_ff <= delay_in;
      slot_ff  <= slot_in;
      hgen_ff  <= hgen_in;
      gen_ff   <= gen_in;
      prod_ff  <= prod_in;
      ridx_ff  <= ridx_in;
      best_ff  <= best_in;
      brec_ff  <= brec_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.handle_out    = rsp_ff.handle_out;
   assign rsp_ch.ok            = rsp_ff.ok;
   assign rsp_ch.delivered     = rsp_ff.delivered;
   assign rsp_ch.out_target    = rsp_ff.msg.target;
   assign rsp_ch.out_tag       = rsp_ff.msg.tag;
   assign rsp_ch.out_kind      = rsp_ff.msg.kind;
   assign rsp_ch.out_value     = rsp_ff.msg.value;
   assign rsp_ch.last          = rsp_ff.last;
   assign rsp_ch.pending_count = rsp_ff.pending_count;
   assign rsp_ch.dropped_count = rsp_ff.dropped_count;

   // The pending counter tracks the armed flags exactly.
   `DMTT_ASSERT_ALWAYS(a_pend_matches, clock, reset, $countones(armed_ff) == int'(pend_ff), "pending count differs from armed slots")
   // Only armed slots can be marked due.
   `DMTT_ASSERT_ALWAYS(a_due_armed, clock, reset, (due_ff & ~armed_ff) == '0, "due flag on a free slot")
   // The divider only finishes while the sequencer waits for it.
   `DMTT_ASSERT_IMPLY(a_div_done, clock, reset, div_rsp.done, state_ff == S_DWAIT, "divider result with no waiting step")
   // An arm leaves its slot armed in the next cycle.
   `DMTT_ASSERT_NEXT(a_arm_sets, clock, reset, state_ff == S_ARM, armed_ff[$past(slot_ff)], "armed slot not marked")

endmodule
